// ----- rtl/percussive_pitch_amp_envelope_top_assert.svh -----
// Assertion macros for the percussive pitch and amplitude envelope.
// Expects clk and rst_n in the scope of every use.
`ifndef PERCUSSIVE_PITCH_AMP_ENVELOPE_TOP_ASSERT_SVH
`define PERCUSSIVE_PITCH_AMP_ENVELOPE_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PCENV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PCENV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcenv_pkg.sv -----
// Shared types and constants of the percussive pitch and amplitude envelope.
// No dependencies; used by every module of the block.
package pcenv_pkg;

    localparam int PITCH_WIDTH  = 24;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEVEL_W      = 17;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int FACTOR_W     = 20;
    localparam int F29_W        = 34;

    // Shared multiplier operand widths: signed, wide enough for every use.
    localparam int MUL_A_W0 = (PITCH_WIDTH + 1 > SAMPLE_WIDTH) ? PITCH_WIDTH + 1 : SAMPLE_WIDTH;
    localparam int MUL_A_W  = (MUL_A_W0 > LEVEL_W + 1) ? MUL_A_W0 : LEVEL_W + 1;
    localparam int MUL_B_W  = FACTOR_W + 1;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam logic [LEVEL_W-1:0]    LEVEL_ONE   = 17'h10000;
    localparam logic [CFG_DATA_W-1:0] SWEEP_ONE   = 16'd8192;
    localparam logic [CFG_DATA_W-1:0] DECAY_RESET = 16'd65529;
    localparam logic [CFG_DATA_W-1:0] SWEEP_RESET = 16'd4096;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PITCH_ENABLE,
        CFG_AMP_ENABLE,
        CFG_PITCH_DECAY,
        CFG_AMP_DECAY,
        CFG_SWEEP_DEPTH
    } pcenv_cfg_addr_t;

    typedef struct packed {
        logic                           restart;
        logic        [PITCH_WIDTH-1:0]  pitch_in;
        logic signed [SAMPLE_WIDTH-1:0] amp_in;
    } pcenv_in_t;

    typedef struct packed {
        logic        [PITCH_WIDTH-1:0]  pitch_out;
        logic signed [SAMPLE_WIDTH-1:0] amp_out;
    } pcenv_out_t;

    typedef struct packed {
        logic                  pitch_enable;
        logic                  amp_enable;
        logic [CFG_DATA_W-1:0] pitch_decay;
        logic [CFG_DATA_W-1:0] amp_decay;
        logic [CFG_DATA_W-1:0] sweep_depth;
    } pcenv_cfg_t;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } pcenv_mul_op_t;

endpackage

// ----- rtl/pcenv_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on pcenv_pkg for operand and product widths.
module pcenv_mul (
    input  logic                                   clk,
    input  pcenv_pkg::pcenv_mul_op_t               op,
    output logic signed [pcenv_pkg::MUL_P_W-1:0]   prod_reg
);

    logic signed [pcenv_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = $signed(op.a) * $signed(op.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/pcenv_seq.sv -----
// Sequencer: holds the decay levels, steps one sample through the shared
// multiplier and owns the result register. Depends on pcenv_pkg.
module pcenv_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcenv_pkg::pcenv_cfg_t                 cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pcenv_pkg::pcenv_in_t                  in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pcenv_pkg::pcenv_out_t                 out_data,
    output pcenv_pkg::pcenv_mul_op_t              mul_op,
    input  logic signed [pcenv_pkg::MUL_P_W-1:0]  mul_prod
);

    `include "percussive_pitch_amp_envelope_top_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR_MUL,
        ST_FACTOR,
        ST_PITCH_MUL,
        ST_PITCH_LVL,
        ST_AMP_LVL,
        ST_DONE,
        ST_OUT
    } state_t;

    localparam int PSHIFT_W = pcenv_pkg::MUL_P_W - 16;

    state_t                                       state_reg, state_next;
    pcenv_pkg::pcenv_in_t                         item_reg, item_next;
    logic [pcenv_pkg::LEVEL_W-1:0]                pitch_level_reg, pitch_level_next;
    logic [pcenv_pkg::LEVEL_W-1:0]                amp_level_reg, amp_level_next;
    logic [pcenv_pkg::FACTOR_W-1:0]               factor_reg, factor_next;
    logic [pcenv_pkg::PITCH_WIDTH-1:0]            pitch_res_reg, pitch_res_next;
    logic signed [pcenv_pkg::SAMPLE_WIDTH-1:0]    amp_res_reg, amp_res_next;
    logic                                         out_valid_reg, out_valid_next;
    pcenv_pkg::pcenv_out_t                        out_data_reg, out_data_next;

    logic                                         sweep_below;
    logic [pcenv_pkg::CFG_DATA_W-1:0]             sweep_coef;
    logic [pcenv_pkg::F29_W-1:0]                  prod_low;
    logic [pcenv_pkg::F29_W-1:0]                  factor29;
    logic [PSHIFT_W-1:0]                          pitch_shift;
    logic                                         pitch_ovf;
    logic                                         pitch_bypass;
    logic                                         in_beat;
    logic                                         out_free;
    logic                                         restart_beat;
    logic                                         levels_full;
    logic                                         levels_capped;
    logic                                         out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Pitch factor in Q.29, then truncate to Q.16.
    assign sweep_below = (cfg.sweep_depth < pcenv_pkg::SWEEP_ONE);
    assign sweep_coef  = sweep_below ? (pcenv_pkg::SWEEP_ONE - cfg.sweep_depth)
                                     : cfg.sweep_depth;
    assign prod_low    = mul_prod[pcenv_pkg::F29_W-1:0];
    assign factor29    = sweep_below
        ? (prod_low + (pcenv_pkg::F29_W'(cfg.sweep_depth) << 16))
        : (((pcenv_pkg::F29_W'(pcenv_pkg::SWEEP_ONE)
             + pcenv_pkg::F29_W'(cfg.sweep_depth)) << 16) - prod_low);

    assign pitch_shift  = mul_prod[pcenv_pkg::MUL_P_W-1:16];
    assign pitch_ovf    = |pitch_shift[PSHIFT_W-1:pcenv_pkg::PITCH_WIDTH];
    assign pitch_bypass = !cfg.pitch_enable || (cfg.sweep_depth == pcenv_pkg::SWEEP_ONE);

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_op.a = '0;
        mul_op.b = '0;
        case (state_reg)
            ST_FACTOR_MUL:
            begin
                mul_op.a = pcenv_pkg::MUL_A_W'(pitch_level_reg);
                mul_op.b = pcenv_pkg::MUL_B_W'(sweep_coef);
            end
            ST_FACTOR:
            begin
                mul_op.a = pcenv_pkg::MUL_A_W'($signed(item_reg.amp_in));
                mul_op.b = pcenv_pkg::MUL_B_W'(amp_level_reg);
            end
            ST_PITCH_MUL:
            begin
                mul_op.a = pcenv_pkg::MUL_A_W'(item_reg.pitch_in);
                mul_op.b = pcenv_pkg::MUL_B_W'(factor_reg);
            end
            ST_PITCH_LVL:
            begin
                mul_op.a = pcenv_pkg::MUL_A_W'(pitch_level_reg);
                mul_op.b = pcenv_pkg::MUL_B_W'(cfg.pitch_decay);
            end
            ST_AMP_LVL:
            begin
                mul_op.a = pcenv_pkg::MUL_A_W'(amp_level_reg);
                mul_op.b = pcenv_pkg::MUL_B_W'(cfg.amp_decay);
            end
            default:
            begin
                mul_op.a = '0;
                mul_op.b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        pitch_level_next = pitch_level_reg;
        amp_level_next   = amp_level_reg;
        factor_next      = factor_reg;
        pitch_res_next   = pitch_res_reg;
        amp_res_next     = amp_res_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    item_next  = in_data;
                    state_next = ST_FACTOR_MUL;
                    if (in_data.restart)
                    begin
                        pitch_level_next = pcenv_pkg::LEVEL_ONE;
                        amp_level_next   = pcenv_pkg::LEVEL_ONE;
                    end
                end
            end
            ST_FACTOR_MUL:
            begin
                state_next = ST_FACTOR;
            end
            ST_FACTOR:
            begin
                factor_next = factor29[pcenv_pkg::FACTOR_W+12:13];
                state_next  = ST_PITCH_MUL;
            end
            ST_PITCH_MUL:
            begin
                amp_res_next = cfg.amp_enable
                    ? mul_prod[pcenv_pkg::SAMPLE_WIDTH+15:16]
                    : item_reg.amp_in;
                state_next = ST_PITCH_LVL;
            end
            ST_PITCH_LVL:
            begin
                if (pitch_bypass)
                begin
                    pitch_res_next = item_reg.pitch_in;
                end
                else if (pitch_ovf)
                begin
                    pitch_res_next = '1;
                end
                else
                begin
                    pitch_res_next = pitch_shift[pcenv_pkg::PITCH_WIDTH-1:0];
                end
                state_next = ST_AMP_LVL;
            end
            ST_AMP_LVL:
            begin
                pitch_level_next = mul_prod[pcenv_pkg::LEVEL_W+15:16];
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                amp_level_next = mul_prod[pcenv_pkg::LEVEL_W+15:16];
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold here until the result register is free.
                if (out_free)
                begin
                    out_data_next.pitch_out = pitch_res_reg;
                    out_data_next.amp_out   = amp_res_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            pitch_level_reg <= pcenv_pkg::LEVEL_ONE;
            amp_level_reg   <= pcenv_pkg::LEVEL_ONE;
            factor_reg      <= '0;
            pitch_res_reg   <= '0;
            amp_res_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            pitch_level_reg <= pitch_level_next;
            amp_level_reg   <= amp_level_next;
            factor_reg      <= factor_next;
            pitch_res_reg   <= pitch_res_next;
            amp_res_reg     <= amp_res_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign restart_beat  = in_beat && in_data.restart;
    assign levels_full   = (pitch_level_reg == pcenv_pkg::LEVEL_ONE)
                        && (amp_level_reg == pcenv_pkg::LEVEL_ONE);
    assign levels_capped = (pitch_level_reg <= pcenv_pkg::LEVEL_ONE)
                        && (amp_level_reg <= pcenv_pkg::LEVEL_ONE);
    assign out_load      = (state_reg == ST_OUT) && out_free;

    `PCENV_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready, "accepted a beat while busy")
    `PCENV_ASSERT_NOW(a_level_bound, 1'b1, levels_capped, "decay level above 1.0")
    `PCENV_ASSERT_NEXT(a_restart_level, restart_beat, levels_full, "levels not reloaded")
    `PCENV_ASSERT_NEXT(a_result_load, out_load, out_valid_reg && in_ready, "result not loaded")

endmodule

// ----- rtl/percussive_pitch_amp_envelope_top.sv -----
// Top level of the percussive pitch and amplitude envelope.
// Depends on pcenv_pkg, pcenv_mul and pcenv_seq.
//
//  channel   direction  handshake            beat payload
//  in        sink       in_valid/in_ready    pcenv_in_t   (restart, pitch_in, amp_in)
//  out       source     out_valid/out_ready  pcenv_out_t  (pitch_out, amp_out)
//  cfg       sink       cfg_we (no wait)     cfg_addr, cfg_data
//
// An input beat is taken in the idle state, then seven sequencer steps follow;
// the single shared multiplier is used for the pitch factor, the amplitude, the
// pitch and two level updates, each read back from its registered product.
// Reset loads the register defaults and sets both decay levels to 1.0.
// A finished result sits in the output register; a new input beat is taken
// while it waits, and the sequencer holds its last step until the slot frees.

module percussive_pitch_amp_envelope_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcenv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pcenv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pcenv_pkg::pcenv_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pcenv_pkg::pcenv_out_t                out_data
);

    pcenv_pkg::pcenv_cfg_t                 cfg_reg, cfg_next;
    pcenv_pkg::pcenv_mul_op_t              mul_op;
    logic signed [pcenv_pkg::MUL_P_W-1:0]  mul_prod;

    // Register file: decode the index, drop writes to unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                pcenv_pkg::CFG_PITCH_ENABLE: cfg_next.pitch_enable = cfg_data[0];
                pcenv_pkg::CFG_AMP_ENABLE:   cfg_next.amp_enable   = cfg_data[0];
                pcenv_pkg::CFG_PITCH_DECAY:  cfg_next.pitch_decay  = cfg_data;
                pcenv_pkg::CFG_AMP_DECAY:    cfg_next.amp_decay    = cfg_data;
                pcenv_pkg::CFG_SWEEP_DEPTH:  cfg_next.sweep_depth  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_enable <= 1'b0;
            cfg_reg.amp_enable   <= 1'b0;
            cfg_reg.pitch_decay  <= pcenv_pkg::DECAY_RESET;
            cfg_reg.amp_decay    <= pcenv_pkg::DECAY_RESET;
            cfg_reg.sweep_depth  <= pcenv_pkg::SWEEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Shared multiplier: every product of the datapath goes through here.
    pcenv_mul u_mul (
        .clk      (clk),
        .op       (mul_op),
        .prod_reg (mul_prod)
    );

    // Sequencer: step the sample, hold levels, drive the result register.
    pcenv_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mul_op    (mul_op),
        .mul_prod  (mul_prod)
    );

endmodule
